// ===== hw/rtl/bdps_pkg.sv =====
// Shared constants, types and helpers for the switch debouncer with PWM hysteresis.
package bdps_pkg;

  localparam int NUM_PINS      = 4;
  localparam int WIDTH_BITS    = 12;
  localparam int CNT_W         = 11;
  localparam int TICKS_W       = 10;
  localparam int CFG_DATA_W    = 12;
  localparam int CFG_INDEX_W   = 3;

  localparam logic [WIDTH_BITS-1:0] PWM_VALID_MIN = WIDTH_BITS'(800);
  localparam logic [WIDTH_BITS-1:0] PWM_VALID_MAX = WIDTH_BITS'(2200);
  localparam logic [CNT_W-1:0]      COUNT_MAX     = CNT_W'(2047);

  localparam logic [TICKS_W-1:0]    DEBOUNCE_RESET = TICKS_W'(50);
  localparam logic [WIDTH_BITS-1:0] LOW_TRIG_RESET  = WIDTH_BITS'(1200);
  localparam logic [WIDTH_BITS-1:0] HIGH_TRIG_RESET = WIDTH_BITS'(1800);

  typedef logic [NUM_PINS-1:0]   pin_mask_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE        = 3'd0,
    CFG_PIN_ENABLE    = 3'd1,
    CFG_PWM_MODE      = 3'd2,
    CFG_INVERT        = 3'd3,
    CFG_ACTION_ENABLE = 3'd4,
    CFG_DEBOUNCE      = 3'd5,
    CFG_LOW_TRIGGER   = 3'd6,
    CFG_HIGH_TRIGGER  = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic               enable;
    pin_mask_t          pin_enable_mask;
    pin_mask_t          pwm_mode_mask;
    pin_mask_t          invert_mask;
    pin_mask_t          action_enable_mask;
    logic [TICKS_W-1:0] debounce_ticks;
    width_t             pwm_low_trigger;
    width_t             pwm_high_trigger;
  } cfg_t;

  typedef struct packed {
    pin_mask_t                        pin_levels;
    logic [NUM_PINS-1:0][WIDTH_BITS-1:0] pulse_width;
  } tick_t;

  typedef struct packed {
    pin_mask_t button_state;
    pin_mask_t action_mask;
    pin_mask_t action_levels;
  } result_t;

  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + count_t'(1);
  endfunction

endpackage

// ===== hw/rtl/bdps_tick_if.sv =====
// Handshake channel carrying one tick word: raw pin levels and four pulse widths.
interface bdps_tick_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pin_levels;
  logic [11:0] pulse_width_a;
  logic [11:0] pulse_width_b;
  logic [11:0] pulse_width_c;
  logic [11:0] pulse_width_d;

  modport source (
    output valid, pin_levels, pulse_width_a, pulse_width_b, pulse_width_c, pulse_width_d,
    input  ready
  );
  modport sink (
    input  valid, pin_levels, pulse_width_a, pulse_width_b, pulse_width_c, pulse_width_d,
    output ready
  );
endinterface

// ===== hw/rtl/bdps_result_if.sv =====
// Handshake channel carrying one result word: debounced state and action edges.
interface bdps_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] button_state;
  logic [3:0] action_mask;
  logic [3:0] action_levels;

  modport source (
    output valid, button_state, action_mask, action_levels,
    input  ready
  );
  modport sink (
    input  valid, button_state, action_mask, action_levels,
    output ready
  );
endinterface

// ===== hw/rtl/bdps_cfg.sv =====
// Configuration register file written through a plain indexed write port.
module bdps_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [bdps_pkg::CFG_INDEX_W-1:0] index,
  input  logic [bdps_pkg::CFG_DATA_W-1:0]  data,
  output bdps_pkg::cfg_t                 cfg
);
  import bdps_pkg::*;

  cfg_index_t sel;
  assign sel = cfg_index_t'(index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable             <= 1'b0;
      cfg.pin_enable_mask    <= '0;
      cfg.pwm_mode_mask      <= '0;
      cfg.invert_mask        <= '0;
      cfg.action_enable_mask <= '0;
      cfg.debounce_ticks     <= DEBOUNCE_RESET;
      cfg.pwm_low_trigger    <= LOW_TRIG_RESET;
      cfg.pwm_high_trigger   <= HIGH_TRIG_RESET;
    end else if (we) begin
      unique case (sel)
        CFG_ENABLE:        cfg.enable             <= data[0];
        CFG_PIN_ENABLE:    cfg.pin_enable_mask    <= data[NUM_PINS-1:0];
        CFG_PWM_MODE:      cfg.pwm_mode_mask      <= data[NUM_PINS-1:0];
        CFG_INVERT:        cfg.invert_mask        <= data[NUM_PINS-1:0];
        CFG_ACTION_ENABLE: cfg.action_enable_mask <= data[NUM_PINS-1:0];
        CFG_DEBOUNCE:      cfg.debounce_ticks     <= data[TICKS_W-1:0];
        CFG_LOW_TRIGGER:   cfg.pwm_low_trigger    <= data[WIDTH_BITS-1:0];
        CFG_HIGH_TRIGGER:  cfg.pwm_high_trigger   <= data[WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end
endmodule

// ===== hw/rtl/bdps_core.sv =====
// Debounce state and the single-pass logic that turns one tick into one result.
module bdps_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  bdps_pkg::cfg_t    cfg,
  input  bdps_pkg::tick_t   tick,
  output bdps_pkg::result_t res
);
  import bdps_pkg::*;

  logic      started, started_next;
  pin_mask_t last_raw_mask, last_raw_mask_next;
  count_t    raw_stable_count, raw_stable_count_next;
  pin_mask_t level_debounced, level_debounced_next;
  pin_mask_t pwm_accepted, pwm_accepted_next;
  pin_mask_t pwm_tentative, pwm_tentative_next;
  count_t    pwm_stable_count, pwm_stable_count_next;
  pin_mask_t actioned_mask, actioned_mask_next;

  pin_mask_t raw, cand, shown_now, shown_next, vals, act, lev;
  logic      force_act, changed;
  count_t    ticks_ext;

  assign ticks_ext = count_t'(cfg.debounce_ticks);
  assign shown_now = (pwm_accepted & cfg.pwm_mode_mask)
                   | (level_debounced & ~cfg.pwm_mode_mask);

  always_comb begin
    started_next          = started;
    last_raw_mask_next    = last_raw_mask;
    raw_stable_count_next = raw_stable_count;
    level_debounced_next  = level_debounced;
    pwm_accepted_next     = pwm_accepted;
    pwm_tentative_next    = pwm_tentative;
    pwm_stable_count_next = pwm_stable_count;
    actioned_mask_next    = actioned_mask;
    force_act = 1'b0;
    changed   = 1'b0;
    act       = '0;
    lev       = '0;
    raw  = tick.pin_levels & cfg.pin_enable_mask & ~cfg.pwm_mode_mask;
    cand = pwm_accepted;

    // Level pins are debounced together as one mask.
    if (!started) begin
      started_next          = 1'b1;
      last_raw_mask_next    = raw;
      level_debounced_next  = raw;
      raw_stable_count_next = '0;
      force_act             = 1'b1;
    end else begin
      if (raw != last_raw_mask) begin
        last_raw_mask_next    = raw;
        raw_stable_count_next = '0;
      end else begin
        raw_stable_count_next = sat_inc(raw_stable_count);
      end
      if ((level_debounced != last_raw_mask_next) && (raw_stable_count_next > ticks_ext)) begin
        level_debounced_next = last_raw_mask_next;
        changed              = 1'b1;
      end
    end

    // Per-pin hysteresis; an out-of-range width forces the pin low.
    for (int i = 0; i < NUM_PINS; i++) begin
      if (!cfg.pwm_mode_mask[i] || (tick.pulse_width[i] < PWM_VALID_MIN)
          || (tick.pulse_width[i] > PWM_VALID_MAX)) begin
        cand[i] = 1'b0;
      end else if (pwm_accepted[i]) begin
        cand[i] = !(tick.pulse_width[i] < cfg.pwm_low_trigger);
      end else begin
        cand[i] = tick.pulse_width[i] > cfg.pwm_high_trigger;
      end
    end

    // The candidate PWM mask is debounced as a whole.
    if (cand != pwm_accepted) begin
      if (cand != pwm_tentative) begin
        pwm_tentative_next    = cand;
        pwm_stable_count_next = '0;
      end else begin
        pwm_stable_count_next = sat_inc(pwm_stable_count);
        if (pwm_stable_count_next > ticks_ext) begin
          pwm_accepted_next = cand;
          changed           = 1'b1;
        end
      end
    end else begin
      pwm_tentative_next    = pwm_accepted;
      pwm_stable_count_next = '0;
    end

    shown_next = (pwm_accepted_next & cfg.pwm_mode_mask)
               | (level_debounced_next & ~cfg.pwm_mode_mask);
    vals = shown_next ^ cfg.invert_mask;

    if (force_act || changed) begin
      for (int i = 0; i < NUM_PINS; i++) begin
        if (cfg.action_enable_mask[i] && (force_act || (vals[i] != actioned_mask[i]))) begin
          actioned_mask_next[i] = vals[i];
          act[i]                = 1'b1;
          lev[i]                = vals[i];
        end
      end
    end

    // While disabled nothing moves and no action is reported.
    if (!cfg.enable) begin
      started_next          = started;
      last_raw_mask_next    = last_raw_mask;
      raw_stable_count_next = raw_stable_count;
      level_debounced_next  = level_debounced;
      pwm_accepted_next     = pwm_accepted;
      pwm_tentative_next    = pwm_tentative;
      pwm_stable_count_next = pwm_stable_count;
      actioned_mask_next    = actioned_mask;
      res.button_state      = shown_now;
      res.action_mask       = '0;
      res.action_levels     = '0;
    end else begin
      res.button_state  = shown_next;
      res.action_mask   = act;
      res.action_levels = lev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      last_raw_mask    <= '0;
      raw_stable_count <= '0;
      level_debounced  <= '0;
      pwm_accepted     <= '0;
      pwm_tentative    <= '0;
      pwm_stable_count <= '0;
      actioned_mask    <= '0;
    end else if (advance) begin
      started          <= started_next;
      last_raw_mask    <= last_raw_mask_next;
      raw_stable_count <= raw_stable_count_next;
      level_debounced  <= level_debounced_next;
      pwm_accepted     <= pwm_accepted_next;
      pwm_tentative    <= pwm_tentative_next;
      pwm_stable_count <= pwm_stable_count_next;
      actioned_mask    <= actioned_mask_next;
    end
  end
endmodule

// ===== hw/rtl/button_debounce_pwm_switch_top.sv =====
// Top level of the four-pin switch debouncer with PWM hysteresis.
//
// Usage: each word on the tick channel is one millisecond tick carrying the raw
// level of four pins and the latest pulse width of each pin. For every tick
// word exactly one word leaves on the result channel, in order, giving the
// debounced pin state, the pins whose function must run and their levels
// after inversion.
// The configuration port is a plain indexed write port; the user must write it
// only while no tick is in flight, and the block itself does not enforce this.
// Flow: a tick word taken from the tick channel is held in the input register,
// processed in a single pass and loaded into the result register. Throughput
// is one word per cycle while the receiver keeps up, limited only by the
// single pass through the comparators and saturating counters between the
// input and result registers.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more tick; tick.ready drops only when both are full.
// Reset clears the debounce state, empties both registers and returns the
// configuration to its defaults (disabled, 50 ticks, triggers 1200 and 1800 us).
module button_debounce_pwm_switch_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bdps_pkg::CFG_DATA_W-1:0]  cfg_data,
  bdps_tick_if.sink                        tick,
  bdps_result_if.source                    result
);
  import bdps_pkg::*;

  cfg_t    cfg;
  tick_t   tick_q;
  logic    tick_q_valid;
  result_t res, res_q;
  logic    advance;

  bdps_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // The held tick moves on whenever the result register is empty or draining.
  assign advance    = tick_q_valid && (!result.valid || result.ready);
  assign tick.ready = !tick_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_q_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      tick_q.pin_levels     <= tick.pin_levels;
      tick_q.pulse_width[0] <= tick.pulse_width_a;
      tick_q.pulse_width[1] <= tick.pulse_width_b;
      tick_q.pulse_width[2] <= tick.pulse_width_c;
      tick_q.pulse_width[3] <= tick.pulse_width_d;
    end
  end

  bdps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cfg     (cfg),
    .tick    (tick_q),
    .res     (res)
  );

  // Result register: loaded as the tick is processed, cleared once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign result.button_state  = res_q.button_state;
  assign result.action_mask   = res_q.action_mask;
  assign result.action_levels = res_q.action_levels;

  // Only pins with an assigned function can ever be actioned.
  a_action_enabled: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.action_mask & ~cfg.action_enable_mask) == '0))
    else $error("action reported on a pin without a function");

  // A level is reported only for a pin that is actioned.
  a_levels_in_mask: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> ((result.action_levels & ~result.action_mask) == '0))
    else $error("action level set on a pin that is not actioned");

  // A tick processed while disabled yields no action.
  a_disabled_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && !cfg.enable) |=> (result.action_mask == '0))
    else $error("action reported while disabled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid straight after reset");
endmodule
